FILE: hw/rtl/rasp_pkg.sv
package rasp_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int COUNT_BITS  = 20;

    // wide enough to compare any accumulator, count or limit without loss
    localparam int CMP_BITS = 65;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int IDX_BITS      = 20;

    localparam logic [0:0] REG_MAX_STRING_LENGTH = 1'b0;
    localparam logic [0:0] REG_MAX_ELEMENT_COUNT = 1'b1;

    localparam logic [31:0] MAX_STRING_LENGTH_RST = 32'd536870912;
    localparam logic [19:0] MAX_ELEMENT_COUNT_RST = 20'd1048575;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_COUNT    = 4'd1,
        PH_COUNT_LF = 4'd2,
        PH_DOLLAR   = 4'd3,
        PH_LEN      = 4'd4,
        PH_LEN_LF   = 4'd5,
        PH_DATA     = 4'd6,
        PH_DATA_CR  = 4'd7,
        PH_DATA_LF  = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_ELEM    = 2'd1,
        EV_CMD     = 2'd2,
        EV_DROP    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        kind_t               event_kind;
        logic [7:0]          payload_byte;
        logic [IDX_BITS-1:0] element_index;
        logic                last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [31:0] max_string_length;
        logic [19:0] max_element_count;
    } cfg_t;

    // results caused by one byte: count 0..2, first in r0
    typedef struct packed {
        logic [1:0] n;
        out_item_t  r0;
        out_item_t  r1;
    } parse_res_t;

endpackage

FILE: hw/rtl/resp_array_stream_parser.sv
// A byte accepted at the input is held in the input register, parsed combinationally,
// and its results are written into the event queue, which drives the output.
// Throughput: one byte per cycle while the two-entry event queue has room; a byte
// with two results needs two free slots, so it can stall the input once the queue fills.
// Reset (rst_n, async, active low): parser idle, counters cleared, queue empty,
// limits back to 536870912 and 1048575.
module resp_array_stream_parser (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rasp_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [rasp_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [rasp_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 byte_valid,
    output logic                                 byte_ready,
    input  rasp_pkg::in_item_t                   byte_item,
    output logic                                 event_valid,
    input  logic                                 event_ready,
    output rasp_pkg::out_item_t                  event_item
);
    import rasp_pkg::*;

    cfg_t       cfg;
    logic       held_valid;
    in_item_t   held_item;
    parse_res_t res;
    logic [1:0] free_slots;
    logic       fire;

    assign fire = held_valid && (free_slots >= res.n);

    rasp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rasp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .fire       (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    rasp_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (held_item),
        .cfg   (cfg),
        .res   (res)
    );

    rasp_evq u_evq (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (fire),
        .res         (res),
        .free_slots  (free_slots),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .event_item  (event_item)
    );

endmodule

FILE: hw/rtl/rasp_cfg.sv
module rasp_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rasp_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [rasp_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [rasp_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output rasp_pkg::cfg_t                       cfg
);
    import rasp_pkg::*;

    logic [31:0] max_str_reg;
    logic [19:0] max_cnt_reg;
    logic        wr_en;
    logic [0:0]  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_str_reg <= MAX_STRING_LENGTH_RST;
            max_cnt_reg <= MAX_ELEMENT_COUNT_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_MAX_STRING_LENGTH: max_str_reg <= pwdata[31:0];
                REG_MAX_ELEMENT_COUNT: max_cnt_reg <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MAX_STRING_LENGTH: prdata = max_str_reg;
            REG_MAX_ELEMENT_COUNT: prdata = {12'd0, max_cnt_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.max_string_length = max_str_reg;
    assign cfg.max_element_count = max_cnt_reg;

endmodule

FILE: hw/rtl/rasp_in_stage.sv
module rasp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  rasp_pkg::in_item_t byte_item,
    input  logic               fire,
    output logic               held_valid,
    output rasp_pkg::in_item_t held_item
);
    import rasp_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // refill in the same cycle the held item is consumed
    assign byte_ready = !valid_reg || fire;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_valid && byte_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            item_reg <= byte_item;
        end
    end

endmodule

FILE: hw/rtl/rasp_parse.sv
module rasp_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  rasp_pkg::in_item_t   item,
    input  rasp_pkg::cfg_t       cfg,
    output rasp_pkg::parse_res_t res
);
    import rasp_pkg::*;

    phase_t                 phase_reg,   phase_next;
    logic [COUNT_BITS-1:0]  elem_rem_reg, elem_rem_next;
    logic [COUNT_BITS-1:0]  elem_num_reg, elem_num_next;
    logic [LENGTH_BITS-1:0] pay_rem_reg, pay_rem_next;
    logic [LENGTH_BITS-1:0] acc_reg,     acc_next;
    logic                   acc_ovf_reg, acc_ovf_next;

    logic [7:0]             b;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [LENGTH_BITS+3:0] acc10;
    logic                   mul_ovf;
    logic [CMP_BITS-1:0]    acc_cmp;
    logic [CMP_BITS-1:0]    cnt_mask;
    logic                   cnt_big;
    logic                   len_big;
    logic [LENGTH_BITS-1:0] pay_dec;
    logic                   last_elem;

    logic                   do_drop;
    logic                   do_restart;
    logic                   start_cmd;
    logic                   e0_valid;
    kind_t                  e0_kind;
    logic [7:0]             e0_byte;
    logic                   eos_drop;
    logic [COUNT_BITS+IDX_BITS-1:0] idx0_ext;
    logic [COUNT_BITS+IDX_BITS-1:0] idx1_ext;

    assign b        = item.data_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit    = 4'(b - CH_ZERO);

    // acc*10 + d; any bit above the length width means saturation
    assign acc10 = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                 + {{LENGTH_BITS{1'b0}}, digit};
    assign mul_ovf = acc10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0;

    assign acc_cmp  = {{(CMP_BITS-LENGTH_BITS){1'b0}}, acc_reg};
    assign cnt_mask = (CMP_BITS'(1) << COUNT_BITS) - CMP_BITS'(1);
    assign cnt_big  = (acc_cmp > {{(CMP_BITS-20){1'b0}}, cfg.max_element_count})
                   || (acc_cmp > cnt_mask);
    assign len_big  = acc_cmp > {{(CMP_BITS-32){1'b0}}, cfg.max_string_length};
    assign pay_dec  = pay_rem_reg - LENGTH_BITS'(1);
    assign last_elem = elem_rem_reg <= COUNT_BITS'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        elem_rem_next = elem_rem_reg;
        elem_num_next = elem_num_reg;
        pay_rem_next  = pay_rem_reg;
        acc_next      = acc_reg;
        acc_ovf_next  = acc_ovf_reg;
        do_drop       = 1'b0;
        do_restart    = 1'b0;
        start_cmd     = 1'b0;
        e0_valid      = 1'b0;
        e0_kind       = EV_PAYLOAD;
        e0_byte       = 8'd0;

        case (phase_reg)
            PH_COUNT, PH_LEN:
            begin
                if (b == CH_CR)
                begin
                    phase_next = (phase_reg == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
                end
                else if (is_digit)
                begin
                    if (acc_ovf_reg || mul_ovf)
                    begin
                        acc_ovf_next = 1'b1;
                        acc_next     = '1;
                    end
                    else
                    begin
                        acc_next = acc10[LENGTH_BITS-1:0];
                    end
                end
            end
            PH_COUNT_LF:
            begin
                if (b != CH_LF)
                begin
                    do_drop    = 1'b1;
                    do_restart = 1'b1;
                end
                else if (acc_ovf_reg || cnt_big)
                begin
                    do_drop = 1'b1;
                end
                else if (acc_reg == '0)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    elem_rem_next = acc_cmp[COUNT_BITS-1:0];
                    elem_num_next = '0;
                    phase_next    = PH_DOLLAR;
                end
            end
            PH_DOLLAR:
            begin
                if (b == CH_DOLLAR)
                begin
                    acc_next     = '0;
                    acc_ovf_next = 1'b0;
                    phase_next   = PH_LEN;
                end
                else
                begin
                    do_drop    = 1'b1;
                    do_restart = 1'b1;
                end
            end
            PH_LEN_LF:
            begin
                if (b != CH_LF)
                begin
                    do_drop    = 1'b1;
                    do_restart = 1'b1;
                end
                else if (acc_ovf_reg || len_big)
                begin
                    do_drop = 1'b1;
                end
                else
                begin
                    pay_rem_next = acc_reg;
                    phase_next   = (acc_reg == '0) ? PH_DATA_CR : PH_DATA;
                end
            end
            PH_DATA:
            begin
                e0_valid     = 1'b1;
                e0_kind      = EV_PAYLOAD;
                e0_byte      = b;
                pay_rem_next = pay_dec;
                if (pay_dec == '0)
                begin
                    phase_next = PH_DATA_CR;
                end
            end
            PH_DATA_CR:
            begin
                if (b == CH_CR)
                begin
                    phase_next = PH_DATA_LF;
                end
                else
                begin
                    do_drop    = 1'b1;
                    do_restart = 1'b1;
                end
            end
            PH_DATA_LF:
            begin
                if (b != CH_LF)
                begin
                    do_drop    = 1'b1;
                    do_restart = 1'b1;
                end
                else
                begin
                    e0_valid = 1'b1;
                    e0_kind  = last_elem ? EV_CMD : EV_ELEM;
                    if (last_elem)
                    begin
                        elem_rem_next = '0;
                        elem_num_next = '0;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        elem_rem_next = elem_rem_reg - COUNT_BITS'(1);
                        elem_num_next = elem_num_reg + COUNT_BITS'(1);
                        phase_next    = PH_DOLLAR;
                    end
                end
            end
            default:
            begin
                // idle, and any code outside the phase list
                phase_next = PH_IDLE;
                start_cmd  = (b == CH_STAR);
            end
        endcase

        if (do_drop)
        begin
            e0_valid   = 1'b1;
            e0_kind    = EV_DROP;
            e0_byte    = 8'd0;
            phase_next = PH_IDLE;
            start_cmd  = do_restart && (b == CH_STAR);
        end

        if (start_cmd)
        begin
            phase_next    = PH_COUNT;
            acc_next      = '0;
            acc_ovf_next  = 1'b0;
            elem_num_next = '0;
            elem_rem_next = '0;
            pay_rem_next  = '0;
        end

        // unfinished command at end of stream
        eos_drop = item.end_of_stream && (phase_next != PH_IDLE);
        if (eos_drop)
        begin
            phase_next = PH_IDLE;
        end
    end

    assign idx0_ext = {{IDX_BITS{1'b0}}, elem_num_reg};
    assign idx1_ext = {{IDX_BITS{1'b0}}, elem_num_next};

    always_comb
    begin
        res.n                = {1'b0, e0_valid} + {1'b0, eos_drop};
        res.r1.event_kind    = EV_DROP;
        res.r1.payload_byte  = 8'd0;
        res.r1.element_index = idx1_ext[IDX_BITS-1:0];
        res.r1.last_of_run   = 1'b1;
        if (e0_valid)
        begin
            res.r0.event_kind    = e0_kind;
            res.r0.payload_byte  = e0_byte;
            res.r0.element_index = idx0_ext[IDX_BITS-1:0];
            res.r0.last_of_run   = !eos_drop;
        end
        else
        begin
            res.r0 = res.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            elem_rem_reg <= '0;
            elem_num_reg <= '0;
            pay_rem_reg  <= '0;
            acc_reg      <= '0;
            acc_ovf_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            elem_rem_reg <= elem_rem_next;
            elem_num_reg <= elem_num_next;
            pay_rem_reg  <= pay_rem_next;
            acc_reg      <= acc_next;
            acc_ovf_reg  <= acc_ovf_next;
        end
    end

endmodule

FILE: hw/rtl/rasp_evq.sv
module rasp_evq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rasp_pkg::parse_res_t res,
    output logic [1:0]           free_slots,
    output logic                 event_valid,
    input  logic                 event_ready,
    output rasp_pkg::out_item_t  event_item
);
    import rasp_pkg::*;

    out_item_t  q_mem [2];
    logic       head_reg;
    logic [1:0] count_reg;
    logic       pop;
    logic [1:0] push_n;
    logic       tail0;
    logic       tail1;

    assign event_valid = count_reg != 2'd0;
    assign event_item  = q_mem[head_reg];
    assign pop         = event_valid && event_ready;
    assign push_n      = push ? res.n : 2'd0;
    // a slot freed by this cycle's pop counts as free
    assign free_slots  = 2'd2 - count_reg + {1'b0, pop};

    assign tail0 = head_reg + count_reg[0];
    assign tail1 = ~tail0;

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_mem[tail0] <= res.r0;
        end
        if (push_n == 2'd2)
        begin
            q_mem[tail1] <= res.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_reg ^ pop;
            count_reg <= count_reg + push_n - {1'b0, pop};
        end
    end

endmodule

FILE: hw/rtl/rasp_checker.sv
module rasp_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 event_valid,
    input logic                                 event_ready,
    input rasp_pkg::out_item_t                  event_item
);
    import rasp_pkg::*;

    // a stalled event item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && !event_ready |=> event_valid && $stable(event_item))
        else $error("event item changed while stalled");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && (event_item.event_kind != EV_PAYLOAD) |->
            event_item.payload_byte == 8'd0)
        else $error("payload byte not zero on a non-payload event");

    // nothing can follow a command completion from the same byte
    a_cmd_last: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && (event_item.event_kind == EV_CMD) |-> event_item.last_of_run)
        else $error("command complete not last of run");

    // both results of a byte are queued together
    a_run_pair: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_ready && !event_item.last_of_run |=> event_valid)
        else $error("second result of a byte missing");

endmodule

bind resp_array_stream_parser rasp_checker u_rasp_checker (.*);
